>>> src/amat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amat_pkg
// Shared types and codes for the adjacency matrix store.
// ----------------------------------------------------------------------------
package amat_pkg;

   localparam int VIN_BITS      = 10;
   localparam int VTX_BITS      = 9;
   localparam int WIN_BITS      = 8;
   localparam int KIND_BITS     = 2;
   localparam int STATUS_BITS   = 2;
   localparam int DEG_OUT_BITS  = 9;
   localparam int TOTAL_BITS    = 17;
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 40;

   localparam logic [VIN_BITS-1:0] VIN_RESET = 10'd512;

   localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_ADJ    = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_DEGREE = 2'd3;

   localparam logic [STATUS_BITS-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NOCHANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE    = 2'd2;

   // status sits in the lowest bits
   typedef struct packed {
      logic [TOTAL_BITS-1:0]   edge_total;
      logic [DEG_OUT_BITS-1:0] degree;
      logic [WIN_BITS-1:0]     stored_weight;
      logic                    adjacent;
      logic [STATUS_BITS-1:0]  status;
   } rsp_type;

   localparam int RSP_BITS = $bits(rsp_type);

   typedef struct packed {
      logic    push;
      rsp_type data;
   } rsp_push_type;

endpackage

>>> src/amat_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amat_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module amat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 262144
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/amat_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amat_ctrl
// Sequencer: clearing sweep, read-modify-write of both matrix entries,
// row walk for the degree, edge counter.
// ----------------------------------------------------------------------------
module amat_ctrl
   import amat_pkg::*;
#(
   parameter int MAX_VERTICES = 512,
   parameter int WEIGHT_BITS  = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [KIND_BITS-1:0]            req_kind,
   input  logic [VTX_BITS-1:0]             req_first,
   input  logic [VTX_BITS-1:0]             req_second,
   input  logic [WIN_BITS-1:0]             req_weight,
   input  logic [VIN_BITS-1:0]             vertices,
   input  logic                            out_free,
   output rsp_push_type                    out_push,
   output logic                            mem_we,
   output logic [2*$clog2(MAX_VERTICES)-1:0] mem_waddr,
   output logic [WEIGHT_BITS-1:0]          mem_wdata,
   output logic [2*$clog2(MAX_VERTICES)-1:0] mem_raddr,
   input  logic [WEIGHT_BITS-1:0]          mem_rdata
);

   localparam int ROW_BITS  = $clog2(MAX_VERTICES);
   localparam int ADDR_BITS = 2 * ROW_BITS;
   localparam int NW = ($clog2(MAX_VERTICES + 1) > VIN_BITS) ?
                       $clog2(MAX_VERTICES + 1) : VIN_BITS;
   localparam int CNT_BITS = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) / 2 + 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EVAL  = 3'd2;
   localparam logic [2:0] ST_WR2   = 3'd3;
   localparam logic [2:0] ST_WALK  = 3'd4;
   localparam logic [2:0] ST_HOLD  = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [ADDR_BITS-1:0]   clr_ff, clr_in;
   logic [KIND_BITS-1:0]   kind_ff, kind_in;
   logic [ROW_BITS-1:0]    a_ff, a_in, b_ff, b_in;
   logic [WEIGHT_BITS-1:0] w_ff, w_in;
   logic [WEIGHT_BITS-1:0] wr_ff, wr_in;
   logic                   rng_ok_ff, rng_ok_in;
   logic                   same_ff, same_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [NW-1:0]          col_ff, col_in;
   logic [NW-1:0]          deg_ff, deg_in;
   logic                   rd_vld_ff, rd_vld_in;
   rsp_type                res_ff, res_in;

   logic [NW-1:0]          n_eff, vin_ext, max_ext;
   logic                   accept, a_ok, b_ok, req_rng_ok;
   logic                   nz, issue, contrib;
   logic [NW-1:0]          deg_final;
   rsp_type                res_c;

   assign vin_ext = NW'(vertices);
   assign max_ext = NW'(MAX_VERTICES);
   assign n_eff   = (vin_ext > max_ext) ? max_ext : vin_ext;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign a_ok       = NW'(req_first) < n_eff;
   assign b_ok       = NW'(req_second) < n_eff;
   assign req_rng_ok = (req_kind == KIND_DEGREE) ? a_ok : (a_ok && b_ok);

   assign nz        = |mem_rdata;
   assign issue     = col_ff < n_eff;
   assign contrib   = rd_vld_ff && nz;
   assign deg_final = deg_ff + NW'(contrib);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      kind_in   = kind_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      w_in      = w_ff;
      wr_in     = wr_ff;
      rng_ok_in = rng_ok_ff;
      same_in   = same_ff;
      cnt_in    = cnt_ff;
      col_in    = col_ff;
      deg_in    = deg_ff;
      rd_vld_in = 1'b0;
      res_in    = res_ff;
      res_c     = '0;
      mem_we    = 1'b0;
      mem_waddr = {a_ff, b_ff};
      mem_wdata = wr_ff;
      mem_raddr = {a_ff, col_ff[ROW_BITS-1:0]};
      out_push  = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + ADDR_BITS'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            mem_raddr = {ROW_BITS'(req_first),
                         (req_kind == KIND_DEGREE) ? ROW_BITS'(0) : ROW_BITS'(req_second)};
            if (accept) begin
               kind_in   = req_kind;
               a_in      = ROW_BITS'(req_first);
               b_in      = ROW_BITS'(req_second);
               w_in      = WEIGHT_BITS'(req_weight);
               same_in   = (req_first == req_second);
               rng_ok_in = req_rng_ok;
               if (req_kind == KIND_DEGREE && req_rng_ok) begin
                  state_in  = ST_WALK;
                  col_in    = NW'(1);
                  deg_in    = '0;
                  rd_vld_in = 1'b1;
               end else begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            res_c.status = STATUS_DONE;
            if (!rng_ok_ff) begin
               res_c.status = STATUS_RANGE;
            end else begin
               case (kind_ff)
                  KIND_INSERT: begin
                     if (!same_ff && !nz && (|w_ff)) begin
                        mem_we              = 1'b1;
                        mem_wdata           = w_ff;
                        wr_in               = w_ff;
                        cnt_in              = cnt_ff + CNT_BITS'(1);
                        res_c.stored_weight = WIN_BITS'(w_ff);
                        res_c.adjacent      = 1'b1;
                     end else begin
                        res_c.status        = STATUS_NOCHANGE;
                        res_c.stored_weight = WIN_BITS'(mem_rdata);
                        res_c.adjacent      = nz;
                     end
                  end
                  KIND_REMOVE: begin
                     if (nz) begin
                        mem_we    = 1'b1;
                        mem_wdata = '0;
                        wr_in     = '0;
                        if (|cnt_ff) begin
                           cnt_in = cnt_ff - CNT_BITS'(1);
                        end
                     end else begin
                        res_c.status = STATUS_NOCHANGE;
                     end
                  end
                  KIND_ADJ: begin
                     res_c.stored_weight = WIN_BITS'(mem_rdata);
                     res_c.adjacent      = nz;
                  end
                  default: begin
                  end
               endcase
            end
            res_c.edge_total = TOTAL_BITS'(cnt_in);
            res_in = res_c;
            if (mem_we) begin
               state_in = ST_WR2;
            end else if (out_free) begin
               out_push.push = 1'b1;
               out_push.data = res_c;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_WR2: begin
            // mirror entry
            mem_we    = 1'b1;
            mem_waddr = {b_ff, a_ff};
            out_push.data = res_ff;
            if (out_free) begin
               out_push.push = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_WALK: begin
            deg_in = deg_final;
            if (issue) begin
               col_in    = col_ff + NW'(1);
               rd_vld_in = 1'b1;
            end else begin
               res_c.status     = STATUS_DONE;
               res_c.degree     = DEG_OUT_BITS'(deg_final);
               res_c.edge_total = TOTAL_BITS'(cnt_ff);
               res_in           = res_c;
               if (out_free) begin
                  out_push.push = 1'b1;
                  out_push.data = res_c;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            out_push.data = res_ff;
            if (out_free) begin
               out_push.push = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      w_ff      <= w_in;
      wr_ff     <= wr_in;
      rng_ok_ff <= rng_ok_in;
      same_ff   <= same_in;
      col_ff    <= col_in;
      deg_ff    <= deg_in;
      res_ff    <= res_in;
   end

   a_cnt_only_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EVAL) |=> $stable(cnt_ff))
      else $error("edge count moved outside evaluation");

   a_wr2_after_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && mem_we) |=> (state_ff == ST_WR2))
      else $error("mirror write skipped");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      out_push.push |-> out_free)
      else $error("result pushed into occupied output register");

   a_rdvld_walk: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_WALK))
      else $error("row read outstanding outside walk");

endmodule

>>> src/adjacency_matrix_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_matrix_store
// Symmetric weighted adjacency matrix of an undirected graph with edge count.
//
//   port group   dir  tdata / tuser                                 role
//   req_*        in   kind | first, second, weight                  operations
//   rsp_*        out  status, adjacent, weight, degree, edge total  one per op
//   csr_*        in   vertices in use                               register
//
// Adjacency query and refused or out-of-range operations: one read, then evaluation.
// Insert / remove that change the matrix: two memory writes (entry and mirror).
// Degree query: walks the row over the vertices in use (at most MAX_VERTICES), one row
// entry read per cycle.
// After reset a clearing sweep writes every entry of the matrix RAM, one per
// cycle (4**clog2(MAX_VERTICES) entries, 262144 by default); req_tready is low.
// A finished result waits in the output register; a further result stalls
// the sequencer until it is taken.
// ----------------------------------------------------------------------------
module adjacency_matrix_store
   import amat_pkg::*;
#(
   parameter int MAX_VERTICES = 512,
   parameter int WEIGHT_BITS  = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [8:0] first_vertex, [17:9] second_vertex, [25:18] edge_weight
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // [1:0] kind
   input  logic [KIND_BITS-1:0]     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [1:0] status, [2] adjacent, [10:3] stored_weight, [19:11] degree,
   // [36:20] edge_total
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_wr_en,
   input  logic [VIN_BITS-1:0]      csr_wr_data
);

   localparam int ADDR_BITS = 2 * $clog2(MAX_VERTICES);

   logic [VIN_BITS-1:0]    vertices_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;
   logic                   out_free;
   rsp_push_type           out_push;
   logic                   mem_we;
   logic [ADDR_BITS-1:0]   mem_waddr, mem_raddr;
   logic [WEIGHT_BITS-1:0] mem_wdata, mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertices_ff <= VIN_RESET;
      end else if (csr_wr_en) begin
         vertices_ff <= csr_wr_data;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   amat_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (2 ** ADDR_BITS)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   amat_ctrl #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .req_first  (req_tdata[8:0]),
      .req_second (req_tdata[17:9]),
      .req_weight (req_tdata[25:18]),
      .vertices   (vertices_ff),
      .out_free   (out_free),
      .out_push   (out_push),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   // output register: one result transfer slot
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_push.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push.push) begin
         rsp_data_ff <= out_push.data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS - RSP_BITS)'(0), rsp_data_ff};

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the adjacency matrix store. A behavioural copy of
// the weighted graph predicts every response; results are matched in order.
// Directed corners come first (occupied pairs, self loops, zero weights,
// indices out of range, a shrunk vertex count), then randomised operations
// over several vertex counts with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;
   import amat_pkg::*;

   localparam int GRAPH_SIZE = 512;
   localparam int IDLE_LIMIT = 1000000;  // covers the clearing sweep after reset
   localparam int LONG_HOLD  = 300;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;
   logic [KIND_BITS-1:0]     req_tuser   = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_wr_en   = 1'b0;
   logic [VIN_BITS-1:0]      csr_wr_data = '0;

   // golden graph
   bit [WIN_BITS-1:0] edge_weights [0:GRAPH_SIZE*GRAPH_SIZE-1];
   int unsigned       stored_edges = 0;
   int unsigned       vertex_limit = 32'(VIN_RESET);
   rsp_type           pending_responses [$];
   int                mismatch_count = 0;

   // traffic shaping
   bit steady       = 1'b0;
   int burst_left   = 0;
   bit hold_request = 1'b0;
   int hold_left    = 0;
   int ready_run    = 0;
   bit ready_phase  = 1'b1;
   int idle_cycles  = 0;

   adjacency_matrix_store uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic rsp_type predict_graph_response(input logic [KIND_BITS-1:0] kind,
                                                      input logic [VTX_BITS-1:0] a,
                                                      input logic [VTX_BITS-1:0] b,
                                                      input logic [WIN_BITS-1:0] w);
      rsp_type     r;
      int unsigned n;
      int          ab;
      int          ba;
      r  = '0;
      n  = (vertex_limit > GRAPH_SIZE) ? GRAPH_SIZE : vertex_limit;
      ab = a * GRAPH_SIZE + b;
      ba = b * GRAPH_SIZE + a;
      if (kind == KIND_DEGREE) begin
         // second vertex plays no part here
         if (a >= n) begin
            r.status = STATUS_RANGE;
         end else begin
            for (int i = 0; i < n; i++)
               if (edge_weights[a * GRAPH_SIZE + i] != 0) r.degree = r.degree + 1'b1;
         end
      end else if (a >= n || b >= n) begin
         r.status = STATUS_RANGE;
      end else begin
         case (kind)
            KIND_INSERT: begin
               if (a != b && edge_weights[ab] == 0 && w != 0) begin
                  edge_weights[ab] = w;
                  edge_weights[ba] = w;
                  stored_edges++;
               end else begin
                  r.status = STATUS_NOCHANGE;
               end
            end
            KIND_REMOVE: begin
               if (edge_weights[ab] != 0) begin
                  edge_weights[ab] = '0;
                  edge_weights[ba] = '0;
                  if (stored_edges != 0) stored_edges--;
               end else begin
                  r.status = STATUS_NOCHANGE;
               end
            end
            default: ;
         endcase
         r.stored_weight = edge_weights[ab];
         r.adjacent      = (edge_weights[ab] != 0) || (edge_weights[ba] != 0);
      end
      r.edge_total = TOTAL_BITS'(stored_edges);
      return r;
   endfunction

   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   // predict on each request transfer, compare on each response transfer
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (csr_wr_en) vertex_limit = 32'(csr_wr_data);
         if (req_tvalid && req_tready)
            pending_responses.push_back(predict_graph_response(req_tuser, req_tdata[8:0],
                                                               req_tdata[17:9],
                                                               req_tdata[25:18]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[RSP_BITS-1:0]);
            if (pending_responses.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, got);
               mismatch_count++;
            end else begin
               want = pending_responses.pop_front();
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("adjacent", 32'(want.adjacent), 32'(got.adjacent));
               check_field("stored_weight", 32'(want.stored_weight),
                           32'(got.stored_weight));
               check_field("degree", 32'(want.degree), 32'(got.degree));
               check_field("edge_total", 32'(want.edge_total), 32'(got.edge_total));
            end
         end
      end
   end

   // receiver: a long hold on request, else always ready when steady, else alternating ready and stall runs
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         if (ready_run == 0) begin
            ready_phase = !ready_phase;
            ready_run   = ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 6);
         end
         ready_run--;
         rsp_tready <= ready_phase;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_op(input logic [KIND_BITS-1:0] kind, input int a, input int b,
                          input int w);
      int                       gap;
      logic [REQ_DATA_BITS-1:0] word;
      if (burst_left == 0) begin
         gap = steady ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      word        = '0;
      word[8:0]   = a[8:0];
      word[17:9]  = b[8:0];
      word[25:18] = w[7:0];
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_responses.size() != 0);
   endtask

   task automatic set_vertex_count(input int count);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count[VIN_BITS-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic int pick_vertex(input int n);
      int roll;
      roll = $urandom_range(0, 99);
      if (n == 0 || roll < 8) return $urandom_range(0, GRAPH_SIZE - 1);
      if (roll < 12 && n < GRAPH_SIZE) return n;
      return $urandom_range(0, n - 1);
   endfunction

   task automatic send_random_op(input int count);
      int                   n;
      int                   roll;
      int                   degree_pct;
      int                   w;
      logic [KIND_BITS-1:0] kind;
      n          = (count > GRAPH_SIZE) ? GRAPH_SIZE : count;
      // row walks are slow on big graphs, keep them rare there
      degree_pct = (n > 64) ? 3 : 15;
      roll       = $urandom_range(0, 99);
      if (roll < degree_pct)  kind = KIND_DEGREE;
      else if (roll < 50)     kind = KIND_INSERT;
      else if (roll < 78)     kind = KIND_REMOVE;
      else                    kind = KIND_ADJ;
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255);
      send_op(kind, pick_vertex(n), pick_vertex(n), w);
   endtask

   task automatic test_basic_operations();
      send_op(KIND_INSERT, 0, 511, 255);
      send_op(KIND_INSERT, 511, 0, 1);      // pair already taken
      send_op(KIND_INSERT, 5, 5, 7);        // self loop
      send_op(KIND_INSERT, 1, 2, 0);        // zero weight refused
      send_op(KIND_ADJ, 511, 0, 0);
      send_op(KIND_DEGREE, 0, 511, 0);
      send_op(KIND_DEGREE, 511, 0, 0);
      send_op(KIND_REMOVE, 511, 0, 0);
      send_op(KIND_REMOVE, 0, 511, 0);      // already gone
      send_op(KIND_REMOVE, 3, 3, 0);
      send_op(KIND_INSERT, 510, 509, 128);
   endtask

   task automatic test_index_range();
      set_vertex_count(4);
      send_op(KIND_INSERT, 0, 3, 85);
      send_op(KIND_INSERT, 4, 0, 9);
      send_op(KIND_INSERT, 0, 4, 9);
      send_op(KIND_REMOVE, 3, 511, 0);
      send_op(KIND_ADJ, 511, 511, 0);
      send_op(KIND_DEGREE, 4, 0, 0);
      send_op(KIND_DEGREE, 3, 511, 0);      // far endpoint ignored
      send_op(KIND_ADJ, 3, 0, 0);
      set_vertex_count(0);
      send_op(KIND_DEGREE, 0, 0, 0);
      send_op(KIND_ADJ, 0, 0, 0);
      set_vertex_count(1);
      send_op(KIND_INSERT, 0, 0, 1);
      send_op(KIND_DEGREE, 0, 0, 0);
   endtask

   // edge 509-510 was hidden while the count was small; it must still be there
   task automatic test_shrunk_register();
      set_vertex_count(GRAPH_SIZE);
      send_op(KIND_ADJ, 509, 510, 0);
      set_vertex_count(1023);
      send_op(KIND_DEGREE, 510, 0, 0);
   endtask

   task automatic test_backpressure();
      set_vertex_count(8);
      steady       = 1'b1;
      hold_request = 1'b1;
      repeat (40) send_random_op(8);
      wait_drained();
      repeat (15) send_random_op(8);
      steady = 1'b0;
   endtask

   task automatic test_random_phases();
      int phase_size  [12] = '{2, 3, 4, 6, 8, 16, 5, 32, 1023, 7, 512, -1};
      int phase_items [12] = '{100, 100, 150, 150, 150, 130, 120, 100, 60, 130, 60, 130};
      int count;
      for (int p = 0; p < 12; p++) begin
         count = (phase_size[p] < 0) ? $urandom_range(1, 1023) : phase_size[p];
         set_vertex_count(count);
         steady = p[0];
         repeat (phase_items[p]) send_random_op(count);
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_basic_operations();
      test_index_range();
      test_shrunk_register();
      test_backpressure();
      test_random_phases();
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
src/amat_pkg.sv
src/amat_ram.sv
src/amat_ctrl.sv
src/adjacency_matrix_store.sv
tb/sv/testbench.sv
